FILE: rtl/core/script_token_scanner_unit_assert.svh
// Assertion macros shared by the scanner RTL.
`ifndef SCRIPT_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_UNIT_ASSERT_SVH
// Property that holds in every cycle outside reset.
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on the next cycle.
`define STS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/core/sts_pkg.sv
// Types, constants and character classes for the script token scanner.
package sts_pkg;

    localparam int OFFSET_BITS_DEF     = 32;
    localparam int KEYWORD_MAX_LEN_DEF = 9;

    localparam logic [5:0] KIND_END     = 6'd0;
    localparam logic [5:0] KIND_INVALID = 6'd1;
    localparam logic [5:0] KIND_IDENT   = 6'd2;
    localparam logic [5:0] KIND_NUMBER  = 6'd3;
    localparam logic [5:0] KIND_STRING  = 6'd4;
    localparam logic [5:0] KIND_PAIR_BASE   = 6'd23;
    localparam logic [5:0] KIND_SINGLE_BASE = 6'd38;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_LINE, MODE_BLOCK, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_OP
    } t_mode;

    typedef struct packed {
        logic       action;
        logic [7:0] source_byte;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [31:0] trivia_length;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic        last_of_run;
    } t_out_item;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        k = KIND_INVALID;
        case (c)
            "&": k = 6'd38;  "*": k = 6'd39;  "[": k = 6'd40;  "]": k = 6'd41;
            ",": k = 6'd42;  "{": k = 6'd43;  "}": k = 6'd44;  "=": k = 6'd45;
            "!": k = 6'd46;  "-": k = 6'd47;  "(": k = 6'd48;  ")": k = 6'd49;
            "%": k = 6'd50;  ".": k = 6'd51;  "|": k = 6'd52;  "+": k = 6'd53;
            "?": k = 6'd54;  ";": k = 6'd55;  "/": k = 6'd56;  "<": k = 6'd57;
            ">": k = 6'd58;
            default: k = KIND_INVALID;
        endcase
        return k;
    endfunction

    // Returns KIND_INVALID when the pair is not an operator.
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        k = KIND_INVALID;
        if (b == "=") begin
            case (a)
                "+": k = 6'd23;  "-": k = 6'd24;  "*": k = 6'd25;  "/": k = 6'd26;
                "%": k = 6'd27;  "&": k = 6'd28;  "|": k = 6'd29;  "=": k = 6'd32;
                "!": k = 6'd33;
                default: k = KIND_INVALID;
            endcase
        end else if (a == b) begin
            case (a)
                "&": k = 6'd30;  "|": k = 6'd31;  "-": k = 6'd34;  "+": k = 6'd35;
                "<": k = 6'd36;  ">": k = 6'd37;
                default: k = KIND_INVALID;
            endcase
        end
        return k;
    endfunction

    function automatic logic pair_starter(input logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "%", "&", "|", "=", "!", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage

FILE: rtl/core/sts_keyword_match.sv
// Parallel compare of the buffered word against the keyword table.
module sts_keyword_match #(
    parameter int KEYWORD_MAX_LEN = sts_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic [KEYWORD_MAX_LEN*8-1:0]     i_word,
    input  logic [$clog2(KEYWORD_MAX_LEN+2)-1:0] i_len,
    output logic [5:0]                       o_kind
);
    import sts_pkg::*;

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);

    function automatic logic hit(input logic [KEYWORD_MAX_LEN*8-1:0] w,
                                 input logic [LW-1:0] l,
                                 input logic [71:0] txt, input int n);
        logic ok;
        ok = (l == LW'(n));
        for (int i = 0; i < 9; i++) begin
            if (i < n && w[i*8 +: 8] != txt[(n-1-i)*8 +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    always_comb begin
        o_kind = KIND_IDENT;
        if      (hit(i_word, i_len, 72'("true"), 4))      o_kind = 6'd5;
        else if (hit(i_word, i_len, 72'("false"), 5))     o_kind = 6'd5;
        else if (hit(i_word, i_len, 72'("catch"), 5))     o_kind = 6'd6;
        else if (hit(i_word, i_len, 72'("class"), 5))     o_kind = 6'd7;
        else if (hit(i_word, i_len, 72'("const"), 5))     o_kind = 6'd8;
        else if (hit(i_word, i_len, 72'("delete"), 6))    o_kind = 6'd9;
        else if (hit(i_word, i_len, 72'("do"), 2))        o_kind = 6'd10;
        else if (hit(i_word, i_len, 72'("else"), 4))      o_kind = 6'd11;
        else if (hit(i_word, i_len, 72'("finally"), 7))   o_kind = 6'd12;
        else if (hit(i_word, i_len, 72'("function"), 8))  o_kind = 6'd13;
        else if (hit(i_word, i_len, 72'("if"), 2))        o_kind = 6'd14;
        else if (hit(i_word, i_len, 72'("interface"), 9)) o_kind = 6'd15;
        else if (hit(i_word, i_len, 72'("let"), 3))       o_kind = 6'd16;
        else if (hit(i_word, i_len, 72'("new"), 3))       o_kind = 6'd17;
        else if (hit(i_word, i_len, 72'("null"), 4))      o_kind = 6'd18;
        else if (hit(i_word, i_len, 72'("return"), 6))    o_kind = 6'd19;
        else if (hit(i_word, i_len, 72'("try"), 3))       o_kind = 6'd20;
        else if (hit(i_word, i_len, 72'("var"), 3))       o_kind = 6'd21;
        else if (hit(i_word, i_len, 72'("while"), 5))     o_kind = 6'd22;
    end

endmodule

FILE: rtl/core/script_token_scanner_unit.sv
// Script token scanner: streaming lexer from bytes to token records.
// One request (a source byte or the end marker) enters per cycle when the result
// queue has room; each request yields zero to two tokens, which leave through a
// four-entry result queue one per cycle while the consumer is ready, so sustained
// rate is one request per cycle while requests produce at most one token each. The
// next scan state and keyword compare are combinational; tokens are queued on accept.
module script_token_scanner_unit #(
    parameter int OFFSET_BITS     = sts_pkg::OFFSET_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = sts_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sts_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sts_pkg::t_out_item o_data
);
    import sts_pkg::*;
    `include "script_token_scanner_unit_assert.svh"

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    t_mode r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic [KEYWORD_MAX_LEN*8-1:0] r_word, n_word;
    logic [LW-1:0] r_wlen, n_wlen;
    logic [OFFSET_BITS-1:0] r_off, n_off, r_triv, n_triv, r_tok, n_tok;
    logic r_star, n_star;

    // Tokens of the current request.
    t_out_item emit_q [3];
    logic [1:0] emit_n;
    logic [5:0] kw_kind;
    logic accept;

    // Result queue.
    t_out_item r_q [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt;

    sts_keyword_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
        .i_word(r_word), .i_len(r_wlen), .o_kind(kw_kind)
    );

    assign o_ready = (r_cnt <= 3'd1);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_q[r_rd];

    always_comb begin
        logic [7:0] b;
        logic [OFFSET_BITS-1:0] o, nx;
        logic begin_it, pend;
        logic [5:0] pk;
        logic [5:0] ek;
        logic [OFFSET_BITS-1:0] eend;
        b = i_data.source_byte;
        o = r_off;
        nx = (r_off != OFF_MAX) ? r_off + 1'b1 : r_off;
        n_mode = r_mode; n_held = r_held; n_word = r_word; n_wlen = r_wlen;
        n_off = r_off; n_triv = r_triv; n_tok = r_tok; n_star = r_star;
        emit_n = 2'd0;
        for (int i = 0; i < 3; i++) emit_q[i] = '0;
        begin_it = 1'b0; pend = 1'b0; ek = KIND_END; eend = o; pk = KIND_INVALID;
        if (i_data.action == ACT_BYTE) begin
            n_off = nx;
            pk = pair_kind(r_held, b);
            unique case (r_mode)
                MODE_LINE: if (b == 8'h0a) n_mode = MODE_IDLE;
                MODE_BLOCK: begin
                    if (r_star && b == "/") begin
                        n_mode = MODE_IDLE; n_star = 1'b0;
                    end else n_star = (b == "*");
                end
                MODE_IDENT: begin
                    if (is_id_start(b) || is_digit(b)) begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                            if (r_wlen == LW'(i)) n_word[i*8 +: 8] = b;
                        if (r_wlen <= LW'(KEYWORD_MAX_LEN)) n_wlen = r_wlen + 1'b1;
                    end else begin
                        pend = 1'b1; ek = kw_kind; eend = o; begin_it = 1'b1;
                    end
                end
                MODE_NUMBER: if (!is_digit(b)) begin
                    pend = 1'b1; ek = KIND_NUMBER; eend = o; begin_it = 1'b1;
                end
                MODE_STRING: if (b == "\"") begin
                    pend = 1'b1; ek = KIND_STRING; eend = nx;
                end
                MODE_OP: begin
                    if (r_held == "/" && b == "/") n_mode = MODE_LINE;
                    else if (r_held == "/" && b == "*") begin
                        n_mode = MODE_BLOCK; n_star = 1'b0;
                    end else if (pk != KIND_INVALID) begin
                        pend = 1'b1; ek = pk; eend = nx;
                    end else begin
                        pend = 1'b1; ek = single_kind(r_held); eend = o; begin_it = 1'b1;
                    end
                end
                default: begin_it = 1'b1;
            endcase
            if (pend) begin
                emit_q[0].token_kind = ek;
                emit_q[0].trivia_length = 32'((r_tok >= r_triv) ? r_tok - r_triv : '0);
                emit_q[0].token_start = 32'(r_tok);
                emit_q[0].token_length = 32'((eend >= r_tok) ? eend - r_tok : '0);
                emit_n = 2'd1;
                n_triv = eend; n_mode = MODE_IDLE;
            end
            if (begin_it) begin
                n_tok = o;
                if (is_space(b)) n_mode = MODE_IDLE;
                else if (is_id_start(b)) begin
                    n_mode = MODE_IDENT; n_word[7:0] = b; n_wlen = LW'(1);
                end else if (is_digit(b)) n_mode = MODE_NUMBER;
                else if (b == "\"") n_mode = MODE_STRING;
                else if (pair_starter(b)) begin
                    n_mode = MODE_OP; n_held = b;
                end else begin
                    emit_q[emit_n].token_kind = single_kind(b);
                    emit_q[emit_n].trivia_length =
                        32'((o >= (pend ? eend : r_triv)) ? o - (pend ? eend : r_triv) : '0);
                    emit_q[emit_n].token_start = 32'(o);
                    emit_q[emit_n].token_length = 32'(nx - o);
                    emit_n = emit_n + 1'b1;
                    n_triv = nx; n_mode = MODE_IDLE;
                end
            end
        end else begin
            pend = 1'b1;
            case (r_mode)
                MODE_IDENT:  ek = kw_kind;
                MODE_NUMBER: ek = KIND_NUMBER;
                MODE_STRING: ek = KIND_STRING;
                MODE_OP:     ek = single_kind(r_held);
                default:     pend = 1'b0;
            endcase
            if (pend) begin
                emit_q[0].token_kind = ek;
                emit_q[0].trivia_length = 32'((r_tok >= r_triv) ? r_tok - r_triv : '0);
                emit_q[0].token_start = 32'(r_tok);
                emit_q[0].token_length = 32'(r_off - r_tok);
                emit_n = 2'd1;
            end
            emit_q[emit_n].token_kind = KIND_END;
            emit_q[emit_n].trivia_length = 32'(r_off - (pend ? r_off : r_triv));
            emit_q[emit_n].token_start = 32'(r_off);
            emit_q[emit_n].token_length = '0;
            emit_n = emit_n + 1'b1;
            n_mode = MODE_IDLE; n_held = '0; n_wlen = '0;
            n_off = '0; n_triv = '0; n_tok = '0; n_star = 1'b0;
        end
        if (emit_n != 2'd0) emit_q[emit_n - 1'b1].last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE; r_held <= '0; r_wlen <= '0; r_off <= '0;
            r_triv <= '0; r_tok <= '0; r_star <= 1'b0;
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            if (accept) begin
                r_mode <= n_mode; r_held <= n_held; r_wlen <= n_wlen; r_off <= n_off;
                r_triv <= n_triv; r_tok <= n_tok; r_star <= n_star;
                r_wr <= r_wr + emit_n;
            end
            if (o_valid && i_ready) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (accept ? {1'b0, emit_n} : 3'd0)
                   - ((o_valid && i_ready) ? 3'd1 : 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
            for (int i = 0; i < 3; i++)
                if (2'(i) < emit_n) r_q[r_wr + 2'(i)] <= emit_q[i];
        end
    end

    `STS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 3'd4, "result queue overflow")
    `STS_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, accept && i_data.action == ACT_END,
        r_mode == MODE_IDLE && r_off == '0, "end request must clear scan state")
    `STS_ASSERT(a_ready_room, i_clk, i_rst_n, !o_ready || r_cnt <= 3'd1,
        "ready raised without room for three tokens")

endmodule

FILE: tb/tb_script_token_scanner_unit.sv
// Self-checking testbench for the script token scanner: directed and random byte streams, checked tokens.
`timescale 1ns / 100ps

module tb_script_token_scanner_unit;
    import sts_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    script_token_scanner_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    t_in_item  pending_requests[$];
    t_out_item expected_tokens[$];
    int        error_count = 0;
    logic      stimulus_done = 1'b0;

    // Predictor state.
    t_mode       lex_mode;
    logic [7:0]  lex_held;
    logic [7:0]  lex_word[9];
    int          lex_word_len;
    logic [31:0] lex_offset;
    logic [31:0] lex_trivia_begin;
    logic [31:0] lex_token_begin;
    logic        lex_star;
    int          tokens_this_request;

    function automatic logic [5:0] own_single_kind(input logic [7:0] c);
        string ops;
        ops = "&*[],{}=!-()%.|+?;/<>";
        for (int i = 0; i < ops.len(); i++)
            if (ops[i] == c) return KIND_SINGLE_BASE + 6'(i);
        return KIND_INVALID;
    endfunction

    function automatic logic [5:0] own_pair_kind(input logic [7:0] a, input logic [7:0] b);
        string pairs;
        pairs = "+=-=*=/=%=&=|=&&||==!=--++<<>>";
        for (int i = 0; i < 15; i++)
            if (pairs[2*i] == a && pairs[2*i+1] == b) return KIND_PAIR_BASE + 6'(i);
        return KIND_INVALID;
    endfunction

    function automatic logic own_pair_start(input logic [7:0] c);
        string pairs;
        pairs = "+=-=*=/=%=&=|=&&||==!=--++<<>>";
        for (int i = 0; i < 15; i++)
            if (pairs[2*i] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic own_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic own_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function automatic logic own_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] keyword_kind_of_word();
        string words[19];
        int    kinds[19];
        logic  hit;
        words = '{"true", "false", "catch", "class", "const", "delete", "do", "else",
                  "finally", "function", "if", "interface", "let", "new", "null",
                  "return", "try", "var", "while"};
        kinds = '{5, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22};
        for (int k = 0; k < 19; k++) begin
            if (words[k].len() == lex_word_len) begin
                hit = 1'b1;
                for (int j = 0; j < lex_word_len; j++)
                    if (words[k][j] != lex_word[j]) hit = 1'b0;
                if (hit) return 6'(kinds[k]);
            end
        end
        return KIND_IDENT;
    endfunction

    task automatic push_token(input logic [5:0] kind, input logic [31:0] stop);
        t_out_item t;
        t.token_kind    = kind;
        t.trivia_length = lex_token_begin >= lex_trivia_begin ?
                          lex_token_begin - lex_trivia_begin : 32'd0;
        t.token_start   = lex_token_begin;
        t.token_length  = stop >= lex_token_begin ? stop - lex_token_begin : 32'd0;
        t.last_of_run   = 1'b0;
        expected_tokens.push_back(t);
        tokens_this_request++;
        lex_trivia_begin = stop;
        lex_mode = MODE_IDLE;
    endtask

    task automatic open_token(input logic [7:0] b, input logic [31:0] o, input logic [31:0] nxt);
        lex_token_begin = o;
        if (own_space(b)) lex_mode = MODE_IDLE;
        else if (own_alpha(b)) begin
            lex_mode = MODE_IDENT;
            lex_word[0] = b;
            lex_word_len = 1;
        end else if (own_digit(b)) lex_mode = MODE_NUMBER;
        else if (b == "\"") lex_mode = MODE_STRING;
        else if (b == "/" || own_pair_start(b)) begin
            lex_mode = MODE_OP;
            lex_held = b;
        end else push_token(own_single_kind(b), nxt);
    endtask

    task automatic lex_reset();
        lex_mode = MODE_IDLE;
        lex_held = 8'd0;
        lex_word_len = 0;
        lex_offset = 32'd0;
        lex_trivia_begin = 32'd0;
        lex_token_begin = 32'd0;
        lex_star = 1'b0;
    endtask

    task automatic predict_tokens(input t_in_item req);
        logic [31:0] o;
        logic [31:0] nxt;
        logic [7:0]  b;
        logic [5:0]  pk;
        tokens_this_request = 0;
        b = req.source_byte;
        if (req.action == ACT_BYTE) begin
            o = lex_offset;
            nxt = o != 32'hFFFF_FFFF ? o + 32'd1 : o;
            lex_offset = nxt;
            case (lex_mode)
                MODE_LINE: if (b == "\n") lex_mode = MODE_IDLE;
                MODE_BLOCK: begin
                    if (lex_star && b == "/") begin
                        lex_mode = MODE_IDLE;
                        lex_star = 1'b0;
                    end else lex_star = (b == "*");
                end
                MODE_IDENT: begin
                    if (own_alpha(b) || own_digit(b)) begin
                        if (lex_word_len < 9) lex_word[lex_word_len] = b;
                        if (lex_word_len <= 9) lex_word_len++;
                    end else begin
                        push_token(keyword_kind_of_word(), o);
                        open_token(b, o, nxt);
                    end
                end
                MODE_NUMBER: if (!own_digit(b)) begin
                    push_token(KIND_NUMBER, o);
                    open_token(b, o, nxt);
                end
                MODE_STRING: if (b == "\"") push_token(KIND_STRING, nxt);
                MODE_OP: begin
                    pk = own_pair_kind(lex_held, b);
                    if (lex_held == "/" && b == "/") lex_mode = MODE_LINE;
                    else if (lex_held == "/" && b == "*") begin
                        lex_mode = MODE_BLOCK;
                        lex_star = 1'b0;
                    end else if (pk != KIND_INVALID) push_token(pk, nxt);
                    else begin
                        push_token(own_single_kind(lex_held), o);
                        open_token(b, o, nxt);
                    end
                end
                default: open_token(b, o, nxt);
            endcase
        end else begin
            case (lex_mode)
                MODE_IDENT:  push_token(keyword_kind_of_word(), lex_offset);
                MODE_NUMBER: push_token(KIND_NUMBER, lex_offset);
                MODE_STRING: push_token(KIND_STRING, lex_offset);
                MODE_OP:     push_token(own_single_kind(lex_held), lex_offset);
                default: ;
            endcase
            lex_token_begin = lex_offset;
            push_token(KIND_END, lex_offset);
            lex_reset();
        end
        if (tokens_this_request > 0)
            expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Acceptance seen at the rising edge, used by the driver at the next falling edge.
    logic req_taken = 1'b0;
    always @(posedge i_clk) req_taken <= i_rst_n && i_valid && o_ready;

    // Driver: requests change on the falling edge.
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (!i_valid || req_taken) begin
            if (send_gap > 0 || pending_requests.size() == 0) begin
                i_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                i_data  <= pending_requests.pop_front();
                i_valid <= 1'b1;
                send_gap = gap_length();
            end
        end
    end

    int recv_gap;
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            i_ready <= 1'b0;
            recv_gap--;
        end else begin
            i_ready <= 1'b1;
            recv_gap = gap_length();
        end
    end

    // Monitor: predicts on accepted requests and checks accepted tokens.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_tokens(i_data);
            if (o_valid && i_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("token count", 32'd1, 32'd0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_data.token_kind !== want.token_kind)
                        report_mismatch("token_kind", 32'(o_data.token_kind),
                                        32'(want.token_kind));
                    if (o_data.trivia_length !== want.trivia_length)
                        report_mismatch("trivia_length", o_data.trivia_length,
                                        want.trivia_length);
                    if (o_data.token_start !== want.token_start)
                        report_mismatch("token_start", o_data.token_start, want.token_start);
                    if (o_data.token_length !== want.token_length)
                        report_mismatch("token_length", o_data.token_length,
                                        want.token_length);
                    if (o_data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(o_data.last_of_run),
                                        32'(want.last_of_run));
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        t_in_item r;
        r.action = ACT_BYTE;
        r.source_byte = b;
        pending_requests.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_end();
        t_in_item r;
        r.action = ACT_END;
        r.source_byte = 8'($urandom_range(0, 255));
        pending_requests.push_back(r);
    endtask

    function automatic string random_fragment();
        string frags[];
        frags = '{"true", "false", "catch", "class", "const", "delete", "do", "else",
                  "finally", "function", "if", "interface", "let", "new", "null",
                  "return", "try", "var", "while", "interfaces", "x", "_a9", "$q",
                  "functionsX", "0", "1234", "\"s t\"", "\"\"", "// c\n", "/* a*b */",
                  "/**/", "+=", "-=", "*=", "/=", "%=", "&=", "|=", "&&", "||", "==",
                  "!=", "--", "++", "<<", ">>", "&", "*", "[", "]", ",", "{", "}", "=",
                  "!", "-", "(", ")", "%", ".", "|", "+", "?", ";", "/", "<", ">", "#",
                  "@", " ", "\t", "\n", "  ", "\r\n", "a1b2"};
        return frags[$urandom_range(0, frags.size() - 1)];
    endfunction

    initial begin
        int sent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data  = '0;
        recv_gap = 0;
        lex_reset();
        for (int i = 0; i < 9; i++) lex_word[i] = 8'd0;

        // Directed: keywords, long words, operators, comments, open string at end.
        queue_text("if x1 interface\t12+=a>>b/c//z\n/*x*/ \"s\"#");
        queue_end();
        queue_text("\"open");
        queue_end();
        queue_text("/* */*/");
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_text("-");
        queue_end();
        queue_end();

        sent = pending_requests.size();
        while (sent < 470) begin
            string f;
            int r;
            r = $urandom_range(0, 99);
            if (r < 75) f = random_fragment();
            else f = "";
            if (r < 75) begin
                queue_text(f);
                sent += f.len();
            end else if (r < 92) begin
                queue_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                queue_end();
                sent++;
            end
        end
        queue_end();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
